// ----- sv/sgo_pkg.sv -----
// Package for the spectral Green's operator: widths, mode codes and the
// configuration register indices. No dependencies.
`default_nettype none
package sgo_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 3;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_GRAD  = 2'd1,
        MODE_DIV   = 2'd2,
        MODE_CURL  = 2'd3
    } t_mode;

    localparam logic [CFG_AW-1:0] REG_OP_MODE   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_COMP_MASK = 2'd1;
    localparam logic [CFG_AW-1:0] REG_REG_EN    = 2'd2;
    localparam logic [CFG_AW-1:0] REG_REPROJ_EN = 2'd3;
endpackage
`default_nettype wire

// ----- sv/spectral_green_operator.sv -----
// Spectral Green's operator top level: a deep pipeline over one Fourier
// coefficient per beat. Depends on sgo_pkg.
//
//  channel | direction | handshake            | payload
//  s_axis  | in        | tvalid/tready        | tdata: 12 fields of DATA_WIDTH
//  m_axis  | out       | tvalid/tready        | tdata: 6 fields, tuser, tlast
//  cfg     | in        | i_cfg_we             | index, data
//
// A beat can enter in any cycle in which the pipe advances. Every item passes
// 16 pipeline registers (input capture, twelve working stages of at most a
// multiply and two saturating adds, three plain delay stages) and then the
// output register, from which its first result beat goes out.
// A normal item yields two beats (solution, then updated field) and freezes the
// pipe from its first beat until its last beat is taken, so each item holds the
// single output port to itself; a mode error item yields one beat.
// A stall freezes the whole pipe together with its valid bits; the output
// register stays a full stage so tready to upstream follows the pipe-enable.
// Reset clears valid bits and configuration registers to their defaults.
`default_nettype none
module spectral_green_operator #(
    parameter int DATA_WIDTH = sgo_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = sgo_pkg::FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // fields from bit 0: field_x_re, field_x_im, field_y_re, field_y_im, field_z_re,
    // field_z_im, green_re, green_im, reg_factor, wave_x, wave_y, wave_z
    input  wire logic [((12*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // fields from bit 0: out_x_re, out_x_im, out_y_re, out_y_im, out_z_re, out_z_im
    output logic [((6*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // fields from bit 0: which_vector, mode_error
    output logic [1:0] m_axis_tuser,
    output logic      m_axis_tlast,
    input  wire logic i_cfg_we,
    input  wire logic [sgo_pkg::CFG_AW-1:0] i_cfg_index,
    input  wire logic [sgo_pkg::CFG_DW-1:0] i_cfg_data
);
    localparam int W = DATA_WIDTH;
    localparam int NS = 16;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef logic signed [W-1:0] t_d;
    typedef struct packed { t_d re; t_d im; } t_c;

    // per-stage working set: 3 field, 3 aux, psi, g, k, reg
    typedef struct packed {
        t_c [2:0] f;
        t_c [2:0] s;
        t_c [2:0] t;
        t_c [2:0] u;
        t_c       g;
        t_d [2:0] k;
        t_d       rf;
        logic [1:0] mode;
        logic [2:0] mask;
        logic     regen;
        logic     reproj;
        logic     err;
    } t_st;

    // rounded product shifted by FRAC_BITS, saturated
    function automatic t_d fmul(input t_d a, input t_d b);
        logic signed [2*W:0] p;
        logic signed [2*W:0] q;
        begin
            p = $signed({a[W-1], a}) * $signed({b[W-1], b});
            if (p < 0) q = -((-p + ({{(2*W){1'b0}}, 1'b1} <<< (FRAC_BITS-1))) >>> FRAC_BITS);
            else       q = (p + ({{(2*W){1'b0}}, 1'b1} <<< (FRAC_BITS-1))) >>> FRAC_BITS;
            if (q > $signed({{(W+1){1'b0}}, VMAX})) fmul = VMAX;
            else if (q < $signed({{(W+1){1'b1}}, VMIN})) fmul = VMIN;
            else fmul = q[W-1:0];
        end
    endfunction

    function automatic t_d sadd(input t_d a, input t_d b);
        logic signed [W:0] s;
        begin
            s = $signed({a[W-1], a}) + $signed({b[W-1], b});
            if (s[W] != s[W-1]) sadd = s[W] ? VMIN : VMAX;
            else sadd = s[W-1:0];
        end
    endfunction

    function automatic t_d ssub(input t_d a, input t_d b);
        logic signed [W:0] s;
        begin
            s = $signed({a[W-1], a}) - $signed({b[W-1], b});
            if (s[W] != s[W-1]) ssub = s[W] ? VMIN : VMAX;
            else ssub = s[W-1:0];
        end
    endfunction

    function automatic t_c cadd(input t_c a, input t_c b);
        cadd.re = sadd(a.re, b.re);
        cadd.im = sadd(a.im, b.im);
    endfunction
    function automatic t_c csub(input t_c a, input t_c b);
        csub.re = ssub(a.re, b.re);
        csub.im = ssub(a.im, b.im);
    endfunction
    // i*k*(a): (-(k*b), k*a)
    function automatic t_c cik(input t_d k, input t_c a);
        cik.re = ssub('0, fmul(k, a.im));
        cik.im = fmul(k, a.re);
    endfunction
    // raw partial products of g*a, kept as {ac, bd, ad, bc} in two t_c
    function automatic t_c pm_re(input t_c g, input t_c a);
        pm_re.re = fmul(g.re, a.re);
        pm_re.im = fmul(g.im, a.im);
    endfunction
    function automatic t_c pm_im(input t_c g, input t_c a);
        pm_im.re = fmul(g.re, a.im);
        pm_im.im = fmul(g.im, a.re);
    endfunction
    function automatic t_c pm_fin(input t_c r, input t_c i);
        pm_fin.re = ssub(r.re, r.im);
        pm_fin.im = sadd(i.re, i.im);
    endfunction

    // configuration
    logic [1:0] r_op_mode;
    logic [2:0] r_comp_mask;
    logic       r_reg_en;
    logic       r_reproj_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode   <= sgo_pkg::MODE_PLAIN;
            r_comp_mask <= 3'b111;
            r_reg_en    <= 1'b0;
            r_reproj_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgo_pkg::REG_OP_MODE:   r_op_mode   <= i_cfg_data[1:0];
                sgo_pkg::REG_COMP_MASK: r_comp_mask <= i_cfg_data[2:0];
                sgo_pkg::REG_REG_EN:    r_reg_en    <= i_cfg_data[0];
                sgo_pkg::REG_REPROJ_EN: r_reproj_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline registers
    t_st  r_st [NS];
    logic r_v  [NS];
    t_st  n_in;
    t_st  n_st [1:NS-1];

    // output expander: holds one item, emits two beats (one for a mode error item)
    logic r_ov;
    logic r_ophase;
    t_st  r_ost;
    logic w_olast;
    logic w_oadv;
    logic w_en;

    assign w_olast = r_ost.err || r_ophase;
    assign w_oadv  = r_ov && m_axis_tready && w_olast;
    assign w_en    = !r_ov || w_oadv;
    assign s_axis_tready = w_en;

    // stage input
    always_comb begin
        t_st a;
        a = '0;
        for (int c = 0; c < 3; c++) begin
            if (r_comp_mask[c]) begin
                a.f[c].re = s_axis_tdata[(2*c)*W +: W];
                a.f[c].im = s_axis_tdata[(2*c+1)*W +: W];
            end
            a.k[c] = s_axis_tdata[(9+c)*W +: W];
        end
        a.g.re   = s_axis_tdata[6*W +: W];
        a.g.im   = s_axis_tdata[7*W +: W];
        a.rf     = s_axis_tdata[8*W +: W];
        a.mode   = r_op_mode;
        a.mask   = r_comp_mask;
        a.regen  = r_reg_en;
        a.reproj = r_reproj_en && (r_comp_mask == 3'b111);
        a.err    = (r_op_mode == sgo_pkg::MODE_GRAD && !r_comp_mask[0]) ||
                   (r_op_mode[1] && r_comp_mask != 3'b111);
        n_in = a;
    end

    // stage logic; each stage does at most one multiply and two saturating add layers
    always_comb begin
        for (int s = 1; s < NS; s++) begin
            t_st a;
            a = r_st[s-1];
            case (s)
                1: // regularise
                    for (int c = 0; c < 3; c++)
                        if (a.regen && a.mask[c]) begin
                            a.f[c].re = fmul(a.f[c].re, a.rf);
                            a.f[c].im = fmul(a.f[c].im, a.rf);
                        end
                2: begin // derivative terms: t = ik_c*f_c, s/u = partial products of g*f
                    for (int c = 0; c < 3; c++) begin
                        a.t[c] = cik(a.k[c], a.f[c]);
                        a.s[c] = pm_re(a.g, a.f[c]);
                        a.u[c] = pm_im(a.g, a.f[c]);
                    end
                end
                3: begin // finish g*f; curl cross terms prepared
                    for (int c = 0; c < 3; c++) a.s[c] = pm_fin(a.s[c], a.u[c]);
                    // u holds curl cross terms
                    a.u[0] = cik(a.k[1], a.f[2]);
                    a.u[1] = cik(a.k[2], a.f[0]);
                    a.u[2] = cik(a.k[0], a.f[1]);
                end
                4: begin
                    // s: plain -> done, grad -> ik*s
                    if (a.mode == sgo_pkg::MODE_GRAD)
                        for (int c = 0; c < 3; c++) a.s[c] = cik(a.k[c], a.s[c]);
                    a.u[0] = csub(a.u[0], cik(a.k[2], a.f[1]));
                    a.u[1] = csub(a.u[1], cik(a.k[0], a.f[2]));
                    a.u[2] = csub(a.u[2], cik(a.k[1], a.f[0]));
                    // divergence sum in t[0]
                    a.t[0] = cadd(a.t[0], a.t[1]);
                end
                5: begin
                    a.t[0] = cadd(a.t[0], a.t[2]);
                    if (a.mode == sgo_pkg::MODE_PLAIN)
                        for (int c = 0; c < 3; c++) if (!a.mask[c]) a.s[c] = '0;
                end
                6: begin // psi partial products in t[1]/t[2]
                    a.t[1] = pm_re(a.g, a.t[0]);
                    a.t[2] = pm_im(a.g, a.t[0]);
                end
                7: begin
                    a.t[0] = pm_fin(a.t[1], a.t[2]); // psi / div solution
                    // curl partials into t[1] etc. reuse u via two stages
                    a.t[1] = pm_re(a.g, a.u[0]);
                    a.t[2] = pm_im(a.g, a.u[0]);
                end
                8: begin
                    a.u[0] = pm_fin(a.t[1], a.t[2]);
                    a.t[1] = pm_re(a.g, a.u[1]);
                    a.t[2] = pm_im(a.g, a.u[1]);
                end
                9: begin
                    a.u[1] = pm_fin(a.t[1], a.t[2]);
                    a.t[1] = pm_re(a.g, a.u[2]);
                    a.t[2] = pm_im(a.g, a.u[2]);
                end
                10: begin
                    a.u[2] = pm_fin(a.t[1], a.t[2]);
                    case (a.mode)
                        sgo_pkg::MODE_DIV: begin
                            a.s[0] = a.t[0];
                            a.s[1] = '0;
                            a.s[2] = '0;
                        end
                        sgo_pkg::MODE_CURL: a.s = a.u;
                        default: ;
                    endcase
                end
                11: // ik_c*psi
                    for (int c = 0; c < 3; c++) a.u[c] = cik(a.k[c], a.t[0]);
                12:
                    if (a.reproj)
                        for (int c = 0; c < 3; c++) a.f[c] = cadd(a.f[c], a.u[c]);
                default: ;
            endcase
            n_st[s] = a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st[0] <= n_in;
            for (int s = 1; s < NS; s++) r_st[s] <= n_st[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_v[s] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= s_axis_tvalid;
            for (int s = 1; s < NS; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_ophase <= 1'b0;
        end else if (w_en) begin
            r_ov     <= r_v[NS-1];
            r_ophase <= 1'b0;
        end else if (r_ov && m_axis_tready) begin
            r_ophase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_ost <= r_st[NS-1];
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int c = 0; c < 3; c++) begin
            if (r_ost.err) begin
                m_axis_tdata[(2*c)*W +: W]   = '0;
                m_axis_tdata[(2*c+1)*W +: W] = '0;
            end else if (r_ophase) begin
                m_axis_tdata[(2*c)*W +: W]   = r_ost.f[c].re;
                m_axis_tdata[(2*c+1)*W +: W] = r_ost.f[c].im;
            end else begin
                m_axis_tdata[(2*c)*W +: W]   = r_ost.s[c].re;
                m_axis_tdata[(2*c+1)*W +: W] = r_ost.s[c].im;
            end
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = w_olast;
    assign m_axis_tuser  = {r_ost.err, r_ophase};

    // second beat only follows an accepted first beat of a normal item
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ophase) |-> $past(r_ov && m_axis_tready && !r_ost.err))
        else $error("second beat without first");
    // an error beat never carries the updated-field flag
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_ost.err |-> !r_ophase)
        else $error("error item in field phase");
    // a pending output beat stays valid while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov)
        else $error("output dropped");
endmodule
`default_nettype wire

// ----- dv/tb_spectral_green_operator.sv -----
// Self-checking testbench for spectral_green_operator: streams random and corner
// coefficients through every mode and many register settings and checks each beat.
// Depends on sgo_pkg and the spectral_green_operator RTL.
`timescale 1ns / 1ps
module tb_spectral_green_operator;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    typedef struct {
        logic [DW-1:0] f [6];
        logic [DW-1:0] g_re, g_im, reg_f;
        logic [DW-1:0] k [3];
    } t_coef;

    typedef struct {
        logic          which;
        logic [DW-1:0] v [6];
        logic          last, err;
    } t_beat;

    typedef struct {
        longint re, im;
    } t_cplx;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [12*DW-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [6*DW-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;
    logic i_cfg_we;
    logic [sgo_pkg::CFG_AW-1:0] i_cfg_index;
    logic [sgo_pkg::CFG_DW-1:0] i_cfg_data;

    spectral_green_operator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the configuration registers.
    sgo_pkg::t_mode cur_mode;
    logic [2:0] cur_mask;
    logic       cur_reg_en, cur_reproj_en;

    t_coef  pending_coefs[$];
    t_beat  expected_beats[$];
    int     fail_count = 0;
    int     beats_seen = 0;
    bit     calm = 0;        // no idling in the last part of the run
    bit     hold_off = 0;    // long receiver stall requested
    int     tx_gap = 0, rx_gap = 0, hold_cnt = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic longint clamp(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // Rounded (halves away from zero) and saturated Q16.16 product.
    function automatic longint qmul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0] mag;
        bit neg;
        p = 128'(signed'(a)) * 128'(signed'(b));
        neg = p < 0;
        mag = neg ? -p : p;
        mag = (mag + (128'd1 << (FB - 1))) >> FB;
        if (neg) return (mag > 128'(-VMIN)) ? VMIN : -longint'(mag);
        return (mag > 128'(VMAX)) ? VMAX : longint'(mag);
    endfunction

    function automatic t_cplx cx(longint re, longint im);
        t_cplx r;
        r.re = re;
        r.im = im;
        return r;
    endfunction

    function automatic t_cplx c_add(t_cplx a, t_cplx b);
        return cx(clamp(a.re + b.re), clamp(a.im + b.im));
    endfunction

    function automatic t_cplx c_sub(t_cplx a, t_cplx b);
        return cx(clamp(a.re - b.re), clamp(a.im - b.im));
    endfunction

    function automatic t_cplx c_mul(t_cplx a, t_cplx b);
        return cx(clamp(qmul(a.re, b.re) - qmul(a.im, b.im)),
                  clamp(qmul(a.re, b.im) + qmul(a.im, b.re)));
    endfunction

    // Multiply by i*k.
    function automatic t_cplx c_ik(longint k, t_cplx a);
        return cx(clamp(-qmul(k, a.im)), qmul(k, a.re));
    endfunction

    function automatic t_cplx c_div(t_cplx g, longint k[3], t_cplx f[3]);
        return c_mul(g, c_add(c_add(c_ik(k[0], f[0]), c_ik(k[1], f[1])),
                              c_ik(k[2], f[2])));
    endfunction

    task automatic predict_green_op(t_coef c);
        t_cplx f[3], sol[3], g, psi;
        longint k[3], rf;
        t_beat b;
        bit all_on;
        all_on = (cur_mask == 3'b111);
        for (int i = 0; i < 3; i++) begin
            f[i] = cur_mask[i] ? cx(longint'(signed'(c.f[2*i])), longint'(signed'(c.f[2*i+1])))
                               : cx(0, 0);
            k[i] = longint'(signed'(c.k[i]));
            sol[i] = cx(0, 0);
        end
        g = cx(longint'(signed'(c.g_re)), longint'(signed'(c.g_im)));
        rf = longint'(signed'(c.reg_f));
        if ((cur_mode == sgo_pkg::MODE_GRAD && !cur_mask[0]) ||
            ((cur_mode == sgo_pkg::MODE_DIV || cur_mode == sgo_pkg::MODE_CURL) && !all_on)) begin
            b.which = 0;
            foreach (b.v[i]) b.v[i] = '0;
            b.last = 1;
            b.err = 1;
            expected_beats.push_back(b);
            return;
        end
        if (cur_reg_en)
            for (int i = 0; i < 3; i++)
                if (cur_mask[i]) f[i] = cx(qmul(f[i].re, rf), qmul(f[i].im, rf));
        case (cur_mode)
            sgo_pkg::MODE_PLAIN:
                for (int i = 0; i < 3; i++) if (cur_mask[i]) sol[i] = c_mul(g, f[i]);
            sgo_pkg::MODE_GRAD:
                for (int i = 0; i < 3; i++) sol[i] = c_ik(k[i], c_mul(g, f[i]));
            sgo_pkg::MODE_DIV: sol[0] = c_div(g, k, f);
            sgo_pkg::MODE_CURL: begin
                sol[0] = c_mul(g, c_sub(c_ik(k[1], f[2]), c_ik(k[2], f[1])));
                sol[1] = c_mul(g, c_sub(c_ik(k[2], f[0]), c_ik(k[0], f[2])));
                sol[2] = c_mul(g, c_sub(c_ik(k[0], f[1]), c_ik(k[1], f[0])));
            end
            default: ;
        endcase
        if (cur_reproj_en && all_on) begin
            psi = c_div(g, k, f);
            for (int i = 0; i < 3; i++) f[i] = c_add(f[i], c_ik(k[i], psi));
        end
        for (int v = 0; v < 2; v++) begin
            b.which = v[0];
            b.last = v[0];
            b.err = 0;
            for (int i = 0; i < 3; i++) begin
                b.v[2*i]   = DW'(v ? f[i].re : sol[i].re);
                b.v[2*i+1] = DW'(v ? f[i].im : sol[i].im);
            end
            expected_beats.push_back(b);
        end
    endtask

    // ---------------- driver ----------------
    // Each accepted beat is predicted at its acceptance edge, with the
    // configuration that is known to be stable while traffic flows. The beat
    // on the bus is always the head of the queue until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_green_op(pending_coefs.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // Hold the beat until it is taken.
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 0;
            end else if (pending_coefs.size() > 0) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    tx_gap <= $urandom_range(0, 2);
                    s_axis_tvalid <= 0;
                end else begin
                    s_axis_tvalid <= 1;
                    s_axis_tdata <= pack_coef(pending_coefs[0]);
                end
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    function automatic logic [12*DW-1:0] pack_coef(t_coef c);
        return {c.k[2], c.k[1], c.k[0], c.reg_f, c.g_im, c.g_re,
                c.f[5], c.f[4], c.f[3], c.f[2], c.f[1], c.f[0]};
    endfunction

    // ---------------- receiver stall and monitor ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else if (hold_off && hold_cnt < 200) begin
            hold_cnt <= hold_cnt + 1;
            m_axis_tready <= 0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            rx_gap <= $urandom_range(0, 2);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    always @(posedge i_clk) begin
        t_beat exp_b;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_seen <= beats_seen + 1;
            if (expected_beats.size() == 0) begin
                $error("unexpected output beat");
                fail_count++;
            end else begin
                exp_b = expected_beats.pop_front();
                if (m_axis_tuser[0] !== exp_b.which) begin
                    $error("which_vector exp %0d got %0d", exp_b.which, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tuser[1] !== exp_b.err) begin
                    $error("mode_error exp %0d got %0d", exp_b.err, m_axis_tuser[1]);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_b.last) begin
                    $error("last_of_item exp %0d got %0d", exp_b.last, m_axis_tlast);
                    fail_count++;
                end
                for (int i = 0; i < 6; i++)
                    if (m_axis_tdata[i*DW +: DW] !== exp_b.v[i]) begin
                        $error("out_%s_%s exp %h got %h", (i < 2) ? "x" : (i < 4) ? "y" : "z",
                               i[0] ? "im" : "re", exp_b.v[i], m_axis_tdata[i*DW +: DW]);
                        fail_count++;
                    end
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [DW-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3: return 32'h00010000;             // 1.0
            4: return 32'hffff0000;             // -1.0
            5: return 32'(signed'($urandom_range(0, 262143)) - 131072);
            6: return {{16{1'b0}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_coef rand_coef();
        t_coef c;
        foreach (c.f[i]) c.f[i] = rand_word();
        foreach (c.k[i]) c.k[i] = rand_word();
        c.g_re = rand_word();
        c.g_im = rand_word();
        c.reg_f = rand_word();
        return c;
    endfunction

    function automatic t_coef const_coef(logic [DW-1:0] w);
        t_coef c;
        foreach (c.f[i]) c.f[i] = w;
        foreach (c.k[i]) c.k[i] = w;
        c.g_re = w;
        c.g_im = w;
        c.reg_f = w;
        return c;
    endfunction

    // Drives one register write; the caller drops the enable.
    task automatic write_reg(logic [sgo_pkg::CFG_AW-1:0] idx,
                             logic [sgo_pkg::CFG_DW-1:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            sgo_pkg::REG_OP_MODE:   cur_mode = sgo_pkg::t_mode'(val[1:0]);
            sgo_pkg::REG_COMP_MASK: cur_mask = val[2:0];
            sgo_pkg::REG_REG_EN:    cur_reg_en = val[0];
            sgo_pkg::REG_REPROJ_EN: cur_reproj_en = val[0];
            default: ;
        endcase
    endtask

    // Wait for the pipe to drain before touching the registers.
    task automatic drain();
        wait (pending_coefs.size() == 0 && !s_axis_tvalid && expected_beats.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic setup(sgo_pkg::t_mode m, logic [2:0] mask, bit re, bit rp);
        drain();
        write_reg(sgo_pkg::REG_OP_MODE, sgo_pkg::CFG_DW'(m));
        write_reg(sgo_pkg::REG_COMP_MASK, mask);
        write_reg(sgo_pkg::REG_REG_EN, sgo_pkg::CFG_DW'(re));
        write_reg(sgo_pkg::REG_REPROJ_EN, sgo_pkg::CFG_DW'(rp));
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tdata = '0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cur_mode = sgo_pkg::MODE_PLAIN;
        cur_mask = 3'b111;
        cur_reg_en = 0;
        cur_reproj_en = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset configuration, field extremes and unit values.
        pending_coefs.push_back(const_coef(32'h7fffffff));
        pending_coefs.push_back(const_coef(32'h80000000));
        pending_coefs.push_back(const_coef(32'h00010000));
        pending_coefs.push_back(const_coef(32'hffff8000));  // -0.5
        pending_coefs.push_back(const_coef('0));
        // Every mode with all components, reprojection and scaling on.
        for (int m = 0; m < 4; m++) begin
            setup(sgo_pkg::t_mode'(m), 3'b111, 1, 1);
            pending_coefs.push_back(const_coef(32'h7fffffff));
            pending_coefs.push_back(rand_coef());
            pending_coefs.push_back(rand_coef());
        end
        // Missing components and the mode-error cases.
        setup(sgo_pkg::MODE_GRAD, 3'b110, 0, 1);
        pending_coefs.push_back(rand_coef());
        setup(sgo_pkg::MODE_DIV, 3'b011, 1, 0);
        pending_coefs.push_back(rand_coef());
        setup(sgo_pkg::MODE_CURL, 3'b000, 0, 0);
        pending_coefs.push_back(rand_coef());
        setup(sgo_pkg::MODE_PLAIN, 3'b101, 1, 1);
        pending_coefs.push_back(rand_coef());
        pending_coefs.push_back(rand_coef());

        // Random phases across random register settings.
        for (int ph = 0; ph < 16; ph++) begin
            setup(sgo_pkg::t_mode'($urandom_range(0, 3)),
                  ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b111,
                  $urandom_range(0, 1), $urandom_range(0, 1));
            if (ph == 13) calm = 1;
            if (ph == 5) hold_off = 1;
            for (int n = 0; n < 83; n++) pending_coefs.push_back(rand_coef());
        end

        drain();
        $display("Covered all four modes, component masks, scaling and reprojection");
        $display("with %0d output beats, random idling and a long receiver stall.",
                 beats_seen);
        if (fail_count == 0)
            $display("tb_spectral_green_operator OK");
        else
            $display("tb_spectral_green_operator NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_spectral_green_operator NOT OK");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/sgo_pkg.sv
sv/spectral_green_operator.sv
dv/tb_spectral_green_operator.sv
